/* sv/tmtc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtc_pkg
// Shared types, codes and helpers of the tempo map tick/time converter.
// ----------------------------------------------------------------------------
package tmtc_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int PROD_W          = 88;

    localparam logic [15:0] TPQ_RESET       = 16'd480;
    localparam logic [23:0] DEF_TEMPO_RESET = 24'd500000;
    localparam logic [47:0] TICK_OUT_MAX    = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_APPEND   = 3'd1,
        OP_FINALIZE = 3'd2,
        OP_TICK2TIM = 3'd3,
        OP_TIM2TICK = 3'd4,
        OP_TEMPO_AT = 3'd5
    } op_t;

    localparam logic [1:0] CFG_TPQ       = 2'd0;
    localparam logic [1:0] CFG_DEF_TEMPO = 2'd1;

    typedef struct packed {
        logic [31:0] tick;
        logic [23:0] tempo;
        logic [63:0] start;
    } entry_t;

    // One multiply-divide request: floor(a * b / d), saturated to 64 bits.
    typedef struct packed {
        logic [63:0] a;
        logic [23:0] b;
        logic [23:0] d;
    } md_req_t;

    function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [23:0] nz(input logic [23:0] d);
        return (d == 24'd0) ? 24'd1 : d;
    endfunction

endpackage
`default_nettype wire

/* sv/tempo_map_tick_time_converter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tempo_map_tick_time_converter_unit
// Tempo map with stable sorted insert, finalize and tick/time/tempo queries.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// beat follows, shown on the result ports for a single cycle with done high.
// The receiver cannot stall that beat, so it must capture it on that edge.
// The table lives in one synchronous memory of MAX_ENTRIES entries (tick,
// tempo, start time) and is walked one entry per cycle by append and the
// queries. Append moves each entry with a larger tick up a slot; it writes
// directly into an empty table and refuses a full one. Tempo at tick scans
// from the top entry down. Tick to time and time to tick take the same scan,
// then run the shared multiply-divide unit, which resolves one quotient bit
// per cycle over an 88-bit product. Finalize runs that unit once per entry.
// The table needs no clearing pass after reset: entries at or above the fill
// count are never read. Configuration writes are always taken and must
// arrive while idle.
// ----------------------------------------------------------------------------
module tempo_map_tick_time_converter_unit #(
    parameter int MAX_ENTRIES = tmtc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  operation,
    input  wire logic [31:0] tick,
    input  wire logic [23:0] tempo,
    input  wire logic [63:0] time_in,
    output logic             done,
    output logic [63:0]      time_out,
    output logic [47:0]      tick_out,
    output logic [23:0]      tempo_out,
    output logic             status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DISP = 8'b0000_0010,
        S_APC  = 8'b0000_0100,
        S_APW  = 8'b0000_1000,
        S_FRD  = 8'b0001_0000,
        S_FEV  = 8'b0010_0000,
        S_QEV  = 8'b0100_0000,
        S_MD   = 8'b1000_0000
    } state_t;

    // Configuration registers.
    logic [15:0] tpq_reg;
    logic [23:0] def_tempo_reg;

    // Control and command registers.
    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   p_reg;
    logic [AW-1:0]   idx_reg;
    tmtc_pkg::op_t   op_reg;
    logic [31:0]     tk_reg;
    logic [23:0]     tp_reg;
    logic [63:0]     tm_reg;

    // Working registers for queries and finalize.
    logic [63:0] bt_reg;
    logic [31:0] btk_reg;
    logic        fwd_reg;
    logic [31:0] cur_tick_reg;
    logic [23:0] cur_tempo_reg;
    logic [31:0] prev_tick_reg;
    logic [23:0] prev_tempo_reg;
    logic [63:0] acc_reg;

    // Result beat.
    logic        done_reg;
    logic [63:0] time_out_reg;
    logic [47:0] tick_out_reg;
    logic [23:0] tempo_out_reg;
    logic        status_reg;

    // Table memory with a registered read port.
    tmtc_pkg::entry_t mem_q [MAX_ENTRIES];
    tmtc_pkg::entry_t rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    tmtc_pkg::entry_t mem_wdata;
    logic [AW-1:0]    rd_addr;

    // Multiply-divide unit.
    logic              md_go;
    tmtc_pkg::md_req_t md_req;
    logic              md_done;
    logic [63:0]       md_q;

    tmtc_pkg::entry_t new_entry;
    logic             hit;
    logic             use_e;
    logic [63:0]      e_bt;
    logic [31:0]      e_btk;
    logic [23:0]      e_t;
    logic             e_fwd;
    logic [31:0]      fin_dt;
    logic [63:0]      fin_sum;
    logic [47:0]      base_tick48;
    logic [64:0]      fwd_sum;
    logic [47:0]      t2t_result;
    logic             cnt_empty;
    logic             cnt_full;
    logic             fin_last;

    assign new_entry   = '{tick: tk_reg, tempo: tp_reg, start: 64'd0};
    assign cnt_empty   = (cnt_reg == '0);
    assign cnt_full    = (cnt_reg == CW'(MAX_ENTRIES));
    assign fin_last    = (CW'(idx_reg) + CW'(1)) == cnt_reg;

    // Search condition for the scan from the top entry down.
    always_comb
    begin
        unique case (op_reg)
            tmtc_pkg::OP_TICK2TIM: hit = rdata_reg.tick < tk_reg;
            tmtc_pkg::OP_TIM2TICK: hit = (cnt_reg == CW'(1)) || (rdata_reg.start < tm_reg);
            tmtc_pkg::OP_TEMPO_AT: hit = rdata_reg.tick <= tk_reg;
            default:               hit = 1'b0;
        endcase
    end

    // Base point of a conversion: the hit entry, else zero at default tempo.
    assign use_e = (state_reg == S_QEV) && hit;
    assign e_bt  = use_e ? rdata_reg.start : 64'd0;
    assign e_btk = use_e ? rdata_reg.tick  : 32'd0;
    assign e_t   = use_e ? rdata_reg.tempo : def_tempo_reg;
    assign e_fwd = tm_reg >= e_bt;

    assign fin_dt = (idx_reg == '0) ? rdata_reg.tick : rdata_reg.tick - prev_tick_reg;

    always_comb
    begin
        if (state_reg == S_FEV)
        begin
            md_req.a = {16'd0, fin_dt, 16'd0};
            md_req.b = (idx_reg == '0) ? def_tempo_reg : prev_tempo_reg;
            md_req.d = tmtc_pkg::nz({8'd0, tpq_reg});
        end
        else if (op_reg == tmtc_pkg::OP_TIM2TICK)
        begin
            md_req.a = e_fwd ? tm_reg - e_bt : e_bt - tm_reg;
            md_req.b = {8'd0, tpq_reg};
            md_req.d = tmtc_pkg::nz(e_t);
        end
        else
        begin
            md_req.a = {16'd0, tk_reg - e_btk, 16'd0};
            md_req.b = e_t;
            md_req.d = tmtc_pkg::nz({8'd0, tpq_reg});
        end
    end

    always_comb
    begin
        md_go = 1'b0;
        priority case (1'b1)
            (state_reg == S_DISP):
                md_go = cnt_empty && (op_reg == tmtc_pkg::OP_TICK2TIM ||
                                      op_reg == tmtc_pkg::OP_TIM2TICK);
            (state_reg == S_QEV):
                md_go = (hit || idx_reg == '0) && (op_reg != tmtc_pkg::OP_TEMPO_AT);
            (state_reg == S_FEV):
                md_go = 1'b1;
            default:
                md_go = 1'b0;
        endcase
    end

    tmtc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (md_go),
        .req   (md_req),
        .done  (md_done),
        .q     (md_q)
    );

    // Post-processing of the quotient.
    assign fin_sum     = tmtc_pkg::sat_add((idx_reg == '0) ? 64'd0 : acc_reg, md_q);
    assign base_tick48 = {btk_reg, 16'd0};
    assign fwd_sum     = {1'b0, md_q} + {17'd0, base_tick48};

    always_comb
    begin
        if (fwd_reg)
        begin
            t2t_result = (fwd_sum > {17'd0, tmtc_pkg::TICK_OUT_MAX}) ?
                         tmtc_pkg::TICK_OUT_MAX : fwd_sum[47:0];
        end
        else
        begin
            t2t_result = (md_q >= {16'd0, base_tick48}) ? 48'd0 :
                         base_tick48 - md_q[47:0];
        end
    end

    // Memory port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = new_entry;
        rd_addr   = idx_reg;
        unique case (state_reg)
            S_DISP:
            begin
                rd_addr = AW'(cnt_reg - CW'(1));
                if (cnt_empty && op_reg == tmtc_pkg::OP_APPEND)
                begin
                    mem_we = 1'b1;
                end
                else if (cnt_empty && op_reg == tmtc_pkg::OP_FINALIZE)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{tick: 32'd0, tempo: def_tempo_reg, start: 64'd0};
                end
            end
            S_APC:
            begin
                rd_addr   = AW'(p_reg - CW'(2));
                mem_we    = 1'b1;
                mem_waddr = AW'(p_reg);
                if (rdata_reg.tick > tk_reg)
                begin
                    mem_wdata = rdata_reg;
                end
            end
            S_APW:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(p_reg);
            end
            S_QEV:
            begin
                rd_addr = idx_reg - AW'(1);
            end
            S_MD:
            begin
                if (md_done && op_reg == tmtc_pkg::OP_FINALIZE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = '{tick: cur_tick_reg, tempo: cur_tempo_reg, start: fin_sum};
                end
            end
            default:
            begin
                rd_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem_q[rd_addr];
    end

    // Configuration port: always ready, two registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg       <= tmtc_pkg::TPQ_RESET;
            def_tempo_reg <= tmtc_pkg::DEF_TEMPO_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tmtc_pkg::CFG_TPQ)
            begin
                tpq_reg <= cfg_data[15:0];
            end
            else if (cfg_index == tmtc_pkg::CFG_DEF_TEMPO)
            begin
                def_tempo_reg <= cfg_data;
            end
        end
    end

    // Command sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    idx_reg <= AW'(cnt_reg - CW'(1));
                    p_reg   <= cnt_reg;
                    priority case (op_reg)
                        tmtc_pkg::OP_CLEAR:
                        begin
                            cnt_reg   <= '0;
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        tmtc_pkg::OP_APPEND:
                        begin
                            if (cnt_full || cnt_empty)
                            begin
                                if (!cnt_full)
                                begin
                                    cnt_reg <= cnt_reg + CW'(1);
                                end
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_APC;
                            end
                        end
                        tmtc_pkg::OP_FINALIZE:
                        begin
                            if (cnt_empty)
                            begin
                                cnt_reg <= CW'(1);
                            end
                            idx_reg   <= '0;
                            state_reg <= S_FRD;
                        end
                        tmtc_pkg::OP_TICK2TIM,
                        tmtc_pkg::OP_TIM2TICK,
                        tmtc_pkg::OP_TEMPO_AT:
                        begin
                            if (!cnt_empty)
                            begin
                                state_reg <= S_QEV;
                            end
                            else if (op_reg == tmtc_pkg::OP_TEMPO_AT)
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_MD;
                            end
                        end
                        default:
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_APC:
                begin
                    if (rdata_reg.tick > tk_reg)
                    begin
                        p_reg <= p_reg - CW'(1);
                        if (p_reg == CW'(1))
                        begin
                            state_reg <= S_APW;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_APW:
                begin
                    cnt_reg   <= cnt_reg + CW'(1);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_FRD:
                begin
                    state_reg <= S_FEV;
                end
                S_FEV:
                begin
                    cur_tick_reg  <= rdata_reg.tick;
                    cur_tempo_reg <= rdata_reg.tempo;
                    state_reg     <= S_MD;
                end
                S_QEV:
                begin
                    if (hit || idx_reg == '0)
                    begin
                        if (op_reg == tmtc_pkg::OP_TEMPO_AT)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_MD;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg - AW'(1);
                    end
                end
                S_MD:
                begin
                    if (md_done)
                    begin
                        if (op_reg == tmtc_pkg::OP_FINALIZE && !fin_last)
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_FRD;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Command payload and result datapath.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg        <= tmtc_pkg::op_t'(operation);
            tk_reg        <= tick;
            tp_reg        <= tempo;
            tm_reg        <= time_in;
            time_out_reg  <= 64'd0;
            tick_out_reg  <= 48'd0;
            tempo_out_reg <= 24'd0;
            status_reg    <= 1'b0;
        end
        if (state_reg == S_DISP)
        begin
            if (op_reg == tmtc_pkg::OP_APPEND && cnt_full)
            begin
                status_reg <= 1'b1;
            end
            if (op_reg == tmtc_pkg::OP_TEMPO_AT && cnt_empty)
            begin
                tempo_out_reg <= def_tempo_reg;
            end
        end
        if (state_reg == S_QEV && op_reg == tmtc_pkg::OP_TEMPO_AT)
        begin
            tempo_out_reg <= rdata_reg.tempo;
        end
        if (md_go && state_reg != S_FEV)
        begin
            bt_reg  <= e_bt;
            btk_reg <= e_btk;
            fwd_reg <= e_fwd;
        end
        if (state_reg == S_MD && md_done)
        begin
            if (op_reg == tmtc_pkg::OP_FINALIZE)
            begin
                acc_reg        <= fin_sum;
                prev_tick_reg  <= cur_tick_reg;
                prev_tempo_reg <= cur_tempo_reg;
            end
            else if (op_reg == tmtc_pkg::OP_TIM2TICK)
            begin
                tick_out_reg <= t2t_result;
            end
            else
            begin
                time_out_reg <= tmtc_pkg::sat_add(bt_reg, md_q);
            end
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign time_out  = time_out_reg;
    assign tick_out  = tick_out_reg;
    assign tempo_out = tempo_out_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

/* sv/tmtc_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtc_muldiv
// Sequential floor(a*b/d): two 32x24 partial products, then one quotient
// bit per cycle over the 88-bit product. Result saturates at 64 bits.
// ----------------------------------------------------------------------------
module tmtc_muldiv (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire tmtc_pkg::md_req_t req,
    output logic                   done,
    output logic [63:0]            q
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_LO   = 5'b00010,
        M_HI   = 5'b00100,
        M_SUM  = 5'b01000,
        M_DIV  = 5'b10000
    } mstate_t;

    mstate_t                       state_reg;
    logic [6:0]                    step_reg;
    logic                          done_reg;
    logic [63:0]                   a_reg;
    logic [23:0]                   b_reg;
    logic [23:0]                   d_reg;
    logic [55:0]                   lo_reg;
    logic [55:0]                   hi_reg;
    logic [tmtc_pkg::PROD_W-1:0]   prod_reg;
    logic [23:0]                   rem_reg;

    logic [24:0] rem_sh;
    logic        ge;
    logic [24:0] rem_sub;

    assign rem_sh  = {rem_reg, prod_reg[tmtc_pkg::PROD_W-1]};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            step_reg  <= 7'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (go)
                    begin
                        state_reg <= M_LO;
                    end
                end
                M_LO:  state_reg <= M_HI;
                M_HI:  state_reg <= M_SUM;
                M_SUM:
                begin
                    step_reg  <= 7'd0;
                    state_reg <= M_DIV;
                end
                M_DIV:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'(tmtc_pkg::PROD_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && go)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
            d_reg <= req.d;
        end
        if (state_reg == M_LO)
        begin
            lo_reg <= a_reg[31:0] * b_reg;
        end
        if (state_reg == M_HI)
        begin
            hi_reg <= a_reg[63:32] * b_reg;
        end
        if (state_reg == M_SUM)
        begin
            prod_reg <= {hi_reg, 32'd0} + {32'd0, lo_reg};
            rem_reg  <= 24'd0;
        end
        if (state_reg == M_DIV)
        begin
            prod_reg <= {prod_reg[tmtc_pkg::PROD_W-2:0], ge};
            rem_reg  <= ge ? rem_sub[23:0] : rem_sh[23:0];
        end
    end

    assign done = done_reg;
    assign q    = (|prod_reg[tmtc_pkg::PROD_W-1:64]) ? {64{1'b1}} : prod_reg[63:0];

endmodule
`default_nettype wire

/* sv/tmtc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtc_checker
// Port-level checks of the command and result beats.
// ----------------------------------------------------------------------------
module tmtc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [63:0] time_out,
    input wire logic [47:0] tick_out,
    input wire logic [23:0] tempo_out,
    input wire logic        status
);

    // An accepted command always makes the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted command");

    // The result beat is shown only once the block is idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // One command yields one beat.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // A refused append carries no conversion result.
    a_refuse_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> time_out == 64'd0 && tick_out == 48'd0 && tempo_out == 24'd0)
        else $error("refused append with nonzero result fields");

endmodule

bind tempo_map_tick_time_converter_unit tmtc_checker u_tmtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .time_out  (time_out),
    .tick_out  (tick_out),
    .tempo_out (tempo_out),
    .status    (status)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tempo map tick/time converter unit.
// ----------------------------------------------------------------------------
// Commands are queued by the stimulus process and handed to the unit by a
// driver on the falling clock edge. A monitor on the rising edge sees every
// command beat, runs it through a local tempo map model and queues the result
// that the unit must return. Each result beat (done high) is compared field by
// field with the oldest queued result. The run walks through several tick
// resolution and default tempo settings, each written while the unit is idle,
// and through phases with and without random sender gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TBL_DEPTH   = tmtc_pkg::MAX_ENTRIES_DEF;
    localparam int STALL_LIMIT = 60000;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] tk;
        logic [23:0] tp;
        logic [63:0] tm;
    } cmd_t;

    typedef struct {
        logic [63:0] time_v;
        logic [47:0] tick_v;
        logic [23:0] tempo_v;
        logic        stat_v;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  operation = '0;
    logic [31:0] tick = '0;
    logic [23:0] tempo = '0;
    logic [63:0] time_in = '0;
    logic        done;
    logic [63:0] time_out;
    logic [47:0] tick_out;
    logic [23:0] tempo_out;
    logic        status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // Queued commands, results still owed by the unit, and beat counters.
    cmd_t    cmd_backlog[$];
    answer_t owed_answers[$];
    int      issued_beats = 0;
    int      taken_beats = 0;
    int      error_count = 0;
    int      gap_pct = 0;
    bit      sender_hold = 1'b0;

    // Local copy of the tempo map and its two registers.
    logic [15:0] m_tpq;
    logic [23:0] m_deftempo;
    logic [31:0] m_tick[TBL_DEPTH];
    logic [23:0] m_tempo[TBL_DEPTH];
    logic [63:0] m_start[TBL_DEPTH];
    int          m_count;

    tempo_map_tick_time_converter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .tick      (tick),
        .tempo     (tempo),
        .time_in   (time_in),
        .done      (done),
        .time_out  (time_out),
        .tick_out  (tick_out),
        .tempo_out (tempo_out),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tempo map arithmetic
    // ------------------------------------------------------------------

    function automatic logic [63:0] add_clip(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // floor(a * b / d), clipped to 64 bits; a zero divisor counts as one.
    function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [23:0] b,
                                                input logic [23:0] d);
        logic [127:0] q;
        q = ({64'd0, a} * {104'd0, b}) / {104'd0, (d == 24'd0) ? 24'd1 : d};
        return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
    endfunction

    // Microseconds (Q16) covered by dtick ticks at a given tempo.
    function automatic logic [63:0] ticks_to_usec(input logic [31:0] dtick,
                                                  input logic [23:0] tpo);
        return scaled_quot({16'd0, dtick, 16'd0}, tpo, {8'd0, m_tpq});
    endfunction

    // Ticks (Q16) covered by dt microseconds (Q16) at a given tempo.
    function automatic logic [63:0] usec_to_ticks(input logic [63:0] dt,
                                                  input logic [23:0] tpo);
        return scaled_quot(dt, {8'd0, m_tpq}, tpo);
    endfunction

    // Applies one command to the local map and returns the result it yields.
    function automatic answer_t map_command(input cmd_t c);
        answer_t     r;
        int          p;
        int          j;
        bit          hit;
        logic [63:0] base_tk;
        logic [63:0] base_tm;
        logic [23:0] rate;
        logic [63:0] fwd;
        logic [63:0] back;
        r = '{default: '0};
        case (c.op)
            tmtc_pkg::OP_CLEAR:
                m_count = 0;
            tmtc_pkg::OP_APPEND:
            begin
                if (m_count >= TBL_DEPTH)
                    r.stat_v = 1'b1;
                else
                begin
                    // Equal ticks stay in arrival order: shift only larger ones.
                    p = m_count;
                    while (p > 0 && m_tick[p-1] > c.tk)
                    begin
                        m_tick[p]  = m_tick[p-1];
                        m_tempo[p] = m_tempo[p-1];
                        m_start[p] = m_start[p-1];
                        p--;
                    end
                    m_tick[p]  = c.tk;
                    m_tempo[p] = c.tp;
                    m_start[p] = '0;
                    m_count++;
                end
            end
            tmtc_pkg::OP_FINALIZE:
            begin
                if (m_count == 0)
                begin
                    m_tick[0]  = '0;
                    m_tempo[0] = m_deftempo;
                    m_count    = 1;
                end
                m_start[0] = ticks_to_usec(m_tick[0], m_deftempo);
                for (int i = 1; i < m_count; i++)
                    m_start[i] = add_clip(m_start[i-1],
                                          ticks_to_usec(m_tick[i] - m_tick[i-1], m_tempo[i-1]));
            end
            tmtc_pkg::OP_TICK2TIM:
            begin
                hit = 1'b0;
                for (int i = m_count - 1; i >= 0 && !hit; i--)
                begin
                    if (m_tick[i] < c.tk)
                    begin
                        r.time_v = add_clip(m_start[i], ticks_to_usec(c.tk - m_tick[i], m_tempo[i]));
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    r.time_v = ticks_to_usec(c.tk, m_deftempo);
            end
            tmtc_pkg::OP_TIM2TICK:
            begin
                base_tk = '0;
                base_tm = '0;
                rate    = m_deftempo;
                // A single entry is used even before its own start time.
                if (m_count == 1)
                begin
                    base_tk = {16'd0, m_tick[0], 16'd0};
                    base_tm = m_start[0];
                    rate    = m_tempo[0];
                end
                else if (m_count >= 2)
                begin
                    j = -1;
                    for (int i = m_count - 1; i >= 0 && j < 0; i--)
                        if (m_start[i] < c.tm)
                            j = i;
                    if (j >= 0)
                    begin
                        base_tk = {16'd0, m_tick[j], 16'd0};
                        base_tm = m_start[j];
                        rate    = m_tempo[j];
                    end
                end
                if (c.tm >= base_tm)
                begin
                    fwd = add_clip(base_tk, usec_to_ticks(c.tm - base_tm, rate));
                    r.tick_v = (fwd > {16'd0, tmtc_pkg::TICK_OUT_MAX}) ?
                               tmtc_pkg::TICK_OUT_MAX : fwd[47:0];
                end
                else
                begin
                    back = usec_to_ticks(base_tm - c.tm, rate);
                    r.tick_v = (back >= base_tk) ? 48'd0 : 48'(base_tk - back);
                end
            end
            tmtc_pkg::OP_TEMPO_AT:
            begin
                if (m_count == 0)
                    r.tempo_v = m_deftempo;
                else
                begin
                    j = 0;
                    hit = 1'b0;
                    for (int i = m_count - 1; i >= 0 && !hit; i--)
                        if (m_tick[i] <= c.tk)
                        begin
                            j = i;
                            hit = 1'b1;
                        end
                    r.tempo_v = m_tempo[j];
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb_top: mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued commands on the falling edge. A beat counts as
    // taken once the monitor has seen it, i.e. taken_beats caught up.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        cmd_t c;
        if (!start || taken_beats == issued_beats)
        begin
            if (rst_n && !sender_hold && cmd_backlog.size() != 0 &&
                $urandom_range(0, 99) >= gap_pct)
            begin
                c = cmd_backlog.pop_front();
                operation <= c.op;
                tick      <= c.tk;
                tempo     <= c.tp;
                time_in   <= c.tm;
                start     <= 1'b1;
                issued_beats++;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every command beat, checks every result beat, and
    // tracks register writes. Also runs the stall watchdog.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        cmd_t    c;
        answer_t want;
        bit      moved;
        moved = 1'b0;
        if (!rst_n)
        begin
            m_tpq      = tmtc_pkg::TPQ_RESET;
            m_deftempo = tmtc_pkg::DEF_TEMPO_RESET;
            m_count    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                if (cfg_index == tmtc_pkg::CFG_TPQ)
                    m_tpq = cfg_data[15:0];
                else if (cfg_index == tmtc_pkg::CFG_DEF_TEMPO)
                    m_deftempo = cfg_data;
            end
            if (done)
            begin
                moved = 1'b1;
                if (owed_answers.size() == 0)
                    report_mismatch("result beat with no command waiting on it");
                else
                begin
                    want = owed_answers.pop_front();
                    if (time_out !== want.time_v)
                        report_mismatch($sformatf("time_out %h, want %h", time_out, want.time_v));
                    if (tick_out !== want.tick_v)
                        report_mismatch($sformatf("tick_out %h, want %h", tick_out, want.tick_v));
                    if (tempo_out !== want.tempo_v)
                        report_mismatch($sformatf("tempo_out %h, want %h",
                                                  tempo_out, want.tempo_v));
                    if (status !== want.stat_v)
                        report_mismatch($sformatf("status %b, want %b", status, want.stat_v));
                end
            end
            // The command beat is predicted after the result check, so a
            // result and a new command on the same edge are kept in order.
            if (start && !busy)
            begin
                moved = 1'b1;
                c.op = operation;
                c.tk = tick;
                c.tp = tempo;
                c.tm = time_in;
                owed_answers = {owed_answers, map_command(c)};
                taken_beats++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: watchdog expired, no beat for %0d cycles", STALL_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_cmd(input logic [2:0] op, input logic [31:0] tk,
                            input logic [23:0] tp, input logic [63:0] tm);
        cmd_t c;
        c.op = op;
        c.tk = tk;
        c.tp = tp;
        c.tm = tm;
        cmd_backlog = {cmd_backlog, c};
    endtask

    // Waits until every queued command has been taken and answered.
    task automatic drain_unit();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || taken_beats != issued_beats ||
               owed_answers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_time();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic logic [31:0] rand_tick();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 4000);
            1: return $urandom;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [23:0] rand_tempo();
        if ($urandom_range(0, 2) == 0)
            return 24'($urandom_range(1, 24'hFFFFFF));
        return 24'($urandom_range(250000, 1500000));
    endfunction

    // One scene: clear, fill a table, usually finalize, then query it.
    task automatic queue_scene();
        logic [31:0] used[$];
        logic [31:0] qt;
        int          fill;
        int          nq;
        int          pick;
        push_cmd(tmtc_pkg::OP_CLEAR, $urandom, 24'($urandom), {$urandom, $urandom});
        pick = $urandom_range(0, 59);
        if (pick == 0)
            fill = $urandom_range(TBL_DEPTH - 2, TBL_DEPTH + 3);
        else if (pick < 5)
            fill = 0;
        else if (pick < 15)
            fill = 1;
        else
            fill = $urandom_range(2, 8);
        for (int i = 0; i < fill; i++)
        begin
            // Now and then repeat an earlier tick to exercise equal ticks.
            if (used.size() != 0 && $urandom_range(0, 4) == 0)
                qt = used[$urandom_range(0, used.size() - 1)];
            else
                qt = rand_tick();
            used = {used, qt};
            push_cmd(tmtc_pkg::OP_APPEND, qt, rand_tempo(), rand_time());
        end
        // Occasionally query the table before its start times are known.
        if ($urandom_range(0, 4) == 0)
            push_cmd(3'($urandom_range(tmtc_pkg::OP_TICK2TIM, tmtc_pkg::OP_TEMPO_AT)),
                     rand_tick(), '0, rand_time());
        if ($urandom_range(0, 9) != 0)
            push_cmd(tmtc_pkg::OP_FINALIZE, $urandom, 24'($urandom), {$urandom, $urandom});
        nq = $urandom_range(4, 14);
        for (int i = 0; i < nq; i++)
        begin
            if (used.size() != 0 && $urandom_range(0, 2) == 0)
                qt = used[$urandom_range(0, used.size() - 1)] + $urandom_range(0, 2) - 1;
            else
                qt = rand_tick();
            pick = $urandom_range(0, 19);
            if (pick == 0)
                push_cmd($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7,
                         $urandom, 24'($urandom), {$urandom, $urandom});
            else if (pick == 1)
                push_cmd(tmtc_pkg::OP_APPEND, qt, rand_tempo(), '0);
            else
                push_cmd(3'($urandom_range(tmtc_pkg::OP_TICK2TIM, tmtc_pkg::OP_TEMPO_AT)),
                         qt, 24'($urandom), rand_time());
        end
    endtask

    initial
    begin
        logic [15:0] tpq_set[6];
        logic [23:0] tempo_set[6];
        int          gap_set[6];
        tpq_set   = '{16'd480, 16'd1, 16'd65535, 16'd96, 16'd0, 16'd480};
        tempo_set = '{24'd500000, 24'd1, 24'hFFFFFF, 24'd600000, 24'd0, 24'd500000};
        gap_set   = '{0, 79, 11, 79, 0, 11};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening on the reset registers: empty table, odd codes,
        // extreme fields, equal ticks and queries before finalize.
        push_cmd(tmtc_pkg::OP_TICK2TIM, 32'd0, '0, '0);
        push_cmd(tmtc_pkg::OP_TICK2TIM, 32'hFFFF_FFFF, '0, '0);
        push_cmd(tmtc_pkg::OP_TIM2TICK, '0, '0, 64'd0);
        push_cmd(tmtc_pkg::OP_TIM2TICK, '0, '0, {64{1'b1}});
        push_cmd(tmtc_pkg::OP_TEMPO_AT, 32'hFFFF_FFFF, '0, '0);
        push_cmd(OP_SPARE6, 32'hFFFF_FFFF, 24'hFFFFFF, {64{1'b1}});
        push_cmd(OP_SPARE7, 32'hFFFF_FFFF, 24'hFFFFFF, {64{1'b1}});
        push_cmd(tmtc_pkg::OP_FINALIZE, '0, '0, '0);
        push_cmd(tmtc_pkg::OP_TEMPO_AT, 32'd0, '0, '0);
        push_cmd(tmtc_pkg::OP_CLEAR, '0, '0, '0);
        push_cmd(tmtc_pkg::OP_APPEND, 32'hFFFF_FFFF, 24'd1, '0);
        push_cmd(tmtc_pkg::OP_APPEND, 32'd0, 24'hFFFFFF, '0);
        push_cmd(tmtc_pkg::OP_APPEND, 32'd960, 24'd250000, '0);
        push_cmd(tmtc_pkg::OP_APPEND, 32'd960, 24'd750000, '0);
        push_cmd(tmtc_pkg::OP_TICK2TIM, 32'd1000, '0, '0);
        push_cmd(tmtc_pkg::OP_TIM2TICK, '0, '0, 64'd1 << 40);
        push_cmd(tmtc_pkg::OP_FINALIZE, '0, '0, '0);
        push_cmd(tmtc_pkg::OP_TICK2TIM, 32'd960, '0, '0);
        push_cmd(tmtc_pkg::OP_TICK2TIM, 32'hFFFF_FFFF, '0, '0);
        push_cmd(tmtc_pkg::OP_TIM2TICK, '0, '0, 64'd0);
        push_cmd(tmtc_pkg::OP_TIM2TICK, '0, '0, {64{1'b1}});
        push_cmd(tmtc_pkg::OP_TEMPO_AT, 32'd960, '0, '0);
        push_cmd(tmtc_pkg::OP_TEMPO_AT, 32'd959, '0, '0);
        push_cmd(tmtc_pkg::OP_CLEAR, '0, '0, '0);
        push_cmd(tmtc_pkg::OP_APPEND, 32'd5000, 24'd400000, '0);
        push_cmd(tmtc_pkg::OP_FINALIZE, '0, '0, '0);
        push_cmd(tmtc_pkg::OP_TIM2TICK, '0, '0, 64'd1000);
        drain_unit();

        // Random phases, each under its own register setting and gap rate.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(tmtc_pkg::CFG_TPQ,
                      {8'd0, (ph == 4) ? 16'($urandom_range(1, 65535)) : tpq_set[ph]});
            write_reg(tmtc_pkg::CFG_DEF_TEMPO,
                      (ph == 4) ? 24'($urandom_range(1, 24'hFFFFFF)) : tempo_set[ph]);
            gap_pct = gap_set[ph];
            while (cmd_backlog.size() < 235)
                queue_scene();
            // Once per phase the sender holds back until the unit has caught up.
            wait (cmd_backlog.size() < 120);
            sender_hold = 1'b1;
            @(negedge clk);
            while (taken_beats != issued_beats || owed_answers.size() != 0)
                @(negedge clk);
            sender_hold = 1'b0;
            drain_unit();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
